// ===== design/mcg_pkg.sv =====
// Shared types and constants for the midpoint circle generator.
// No dependencies; every other design file imports this package.
package mcg_pkg;

    localparam int CX_W      = 10;
    localparam int CY_W      = 6;
    localparam int RADIUS_W  = 6;
    localparam int OFFSET_W  = 7;
    localparam int DEC_W     = 12;
    localparam int COUNT_W   = 6;

    localparam int MAX_RADIUS  = 63;
    localparam int MAX_RESULTS = 48;

    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 32;

    typedef struct packed {
        logic                pixel_on;
        logic [RADIUS_W-1:0] radius;
        logic [CY_W-1:0]     center_y;
        logic [CX_W-1:0]     center_x;
    } circle_t;

    typedef struct packed {
        logic                       out_pixel_on;
        logic signed [OFFSET_W-1:0] offset_b;
        logic [OFFSET_W-1:0]        offset_a;
        logic [CY_W-1:0]            out_center_y;
        logic [CX_W-1:0]            out_center_x;
    } point_t;

    // Handshake between the queue and the step engine.
    typedef struct packed {
        logic    valid;
        circle_t circle;
    } queue_out_t;

endpackage

// ===== design/midpoint_circle_generator.sv =====
// Top level of the midpoint circle generator.
// Depends on mcg_pkg, mcg_front and mcg_back.
//
// Each request on the s_ channel describes one circle: center, radius and
// pixel value. The block answers with a run of offset pairs (a, b) on the m_
// channel, each carrying the center and pixel value, so downstream logic can
// mirror it into the eight symmetric points. The first pair is (0, radius);
// m_tlast marks the final pair of each circle, which lies just past the
// diagonal. A radius of r gives about 0.71*r + 2 pairs, at most 46.
// The step engine produces one pair per cycle while m_tready does not stall the
// output; each circle is first loaded from the queue while the engine is idle.
// A request is queued, then loaded into the engine; its first pair is registered onto m_tvalid.
// A two-entry request queue lets s_tready stay high while a circle is being
// drawn; it drops only when the queue is full.
// When m_tready is low the output register holds its pair and the step
// engine waits; nothing is lost or repeated.
// Reset (aresetn low at a clock edge) empties the queue, stops the engine
// and drops m_tvalid.
module midpoint_circle_generator import mcg_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // center_x, center_y, radius, pixel_on, zero pad
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // out_center_x, out_center_y, offset_a, offset_b,
                                           // out_pixel_on, zero pad
    output logic                m_tlast
);

    queue_out_t q_out;
    logic       q_pop;

    mcg_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_out    (q_out),
        .q_pop    (q_pop)
    );

    mcg_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_in     (q_out),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== design/mcg_front.sv =====
// Input side of the circle generator: accepts circle requests, clamps the
// radius and holds them in a two-entry queue. Depends on mcg_pkg.
module mcg_front import mcg_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // center_x, center_y, radius, pixel_on, zero pad
    output queue_out_t          q_out,
    input  logic                q_pop
);

    localparam logic [RADIUS_W-1:0] RADIUS_LIMIT = RADIUS_W'(MAX_RADIUS);

    circle_t     entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    circle_t     in_circle;
    logic        push;
    logic        pop;

    always_comb begin
        in_circle          = circle_t'(s_tdata[$bits(circle_t)-1:0]);
        if (in_circle.radius > RADIUS_LIMIT) begin
            in_circle.radius = RADIUS_LIMIT;
        end
    end

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && (count_reg != 2'd0);

    assign q_out.valid  = (count_reg != 2'd0);
    assign q_out.circle = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_circle;
        end
    end

endmodule

// ===== design/mcg_back.sv =====
// Step engine of the circle generator: runs the midpoint recurrence for one
// circle at a time and drives the registered result channel. Depends on mcg_pkg.
module mcg_back import mcg_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  queue_out_t          q_in,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // out_center_x, out_center_y, offset_a, offset_b,
                                           // out_pixel_on, zero pad
    output logic                m_tlast
);

    localparam logic [COUNT_W-1:0] LAST_INDEX = COUNT_W'(MAX_RESULTS - 1);

    logic                       busy_reg, busy_next;
    logic [OFFSET_W-1:0]        a_reg, a_next;
    logic signed [OFFSET_W-1:0] b_reg, b_next;
    logic signed [DEC_W-1:0]    d_reg, d_next;
    logic [COUNT_W-1:0]         k_reg, k_next;
    circle_t                    circle_reg;
    logic                       out_valid_reg, out_valid_next;
    point_t                     out_point_reg;
    logic                       out_last_reg;

    logic                       out_free;
    logic                       emit;
    logic                       is_last;
    logic [OFFSET_W-1:0]        a_inc;
    logic signed [OFFSET_W-1:0] b_step;
    logic signed [DEC_W-1:0]    a_ext, b_ext, d_add, d_init;
    point_t                     cur_point;

    assign out_free = !out_valid_reg || m_tready;
    assign emit     = busy_reg && out_free;
    assign q_pop    = !busy_reg && q_in.valid;

    // The pair just past the diagonal is still emitted, so the test uses b and a
    // of the pair being sent out.
    assign is_last = ($signed({b_reg[OFFSET_W-1], b_reg}) < $signed({1'b0, a_reg}))
                     || (k_reg == LAST_INDEX);

    always_comb begin
        a_inc  = a_reg + OFFSET_W'(1);
        b_step = (d_reg > 0) ? (b_reg - OFFSET_W'(1)) : b_reg;
        a_ext  = $signed({{(DEC_W-OFFSET_W){1'b0}}, a_inc});
        b_ext  = $signed({{(DEC_W-OFFSET_W){b_step[OFFSET_W-1]}}, b_step});
        if (d_reg > 0) begin
            d_add = ((a_ext - b_ext) <<< 2) + DEC_W'(10);
        end else begin
            d_add = (a_ext <<< 2) + DEC_W'(6);
        end
        d_init = DEC_W'(3) - (DEC_W'(q_in.circle.radius) <<< 1);
    end

    always_comb begin
        cur_point.out_center_x = circle_reg.center_x;
        cur_point.out_center_y = circle_reg.center_y;
        cur_point.offset_a     = a_reg;
        cur_point.offset_b     = b_reg;
        cur_point.out_pixel_on = circle_reg.pixel_on;
    end

    always_comb begin
        busy_next      = busy_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        d_next         = d_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg && !m_tready;
        priority if (emit) begin
            out_valid_next = 1'b1;
            a_next         = a_inc;
            b_next         = b_step;
            d_next         = d_reg + d_add;
            k_next         = k_reg + COUNT_W'(1);
            busy_next      = !is_last;
        end else if (q_pop) begin
            busy_next = 1'b1;
            a_next    = '0;
            b_next    = $signed({1'b0, q_in.circle.radius});
            d_next    = d_init;
            k_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            a_reg         <= '0;
            b_reg         <= '0;
            d_reg         <= '0;
            k_reg         <= '0;
        end else begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            d_reg         <= d_next;
            k_reg         <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            circle_reg <= q_in.circle;
        end
        if (emit) begin
            out_point_reg <= cur_point;
            out_last_reg  <= is_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'(out_point_reg);
    assign m_tlast  = out_last_reg;

endmodule
